[src/ellipse_phantom_rasterizer_top_defines.svh]
// ---------------------------------------------------------------------------
// ellipse phantom rasterizer assertion macros
// concurrent checks on clk, disabled while arst_n is low
// ---------------------------------------------------------------------------
`ifndef ELLIPSE_PHANTOM_RASTERIZER_TOP_DEFINES_SVH
`define ELLIPSE_PHANTOM_RASTERIZER_TOP_DEFINES_SVH

// same-cycle implication
`define EPR_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("same-cycle check failed");

// next-cycle implication
`define EPR_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("next-cycle check failed");

`endif

[src/epr_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// epr_pkg
// item types, register indexes and fixed widths of the rasterizer
// ---------------------------------------------------------------------------
package epr_pkg;

	localparam int COORD_BITS   = 24;
	localparam int AXIS_BITS    = 23;
	localparam int POWER_BITS   = 16;
	localparam int PIX_BITS     = 10;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 23;
	localparam int SAMPLE_COUNT = 4;

	localparam logic MODE_LOAD  = 1'b0;
	localparam logic MODE_QUERY = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_X_STEP      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_Y_STEP      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_X_PARTS     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_Y_PARTS     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ELL_COUNT   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_CORNER_MODE = 3'd5;

	typedef struct packed {
		logic                         mode;
		logic [2:0]                   entry_index;
		logic signed [COORD_BITS-1:0] center_x;
		logic signed [COORD_BITS-1:0] center_y;
		logic [AXIS_BITS-1:0]         axis_x;
		logic [AXIS_BITS-1:0]         axis_y;
		logic [POWER_BITS-1:0]        entry_power;
		logic [PIX_BITS-1:0]          pixel_row;
		logic [PIX_BITS-1:0]          pixel_col;
	} cmd_t;

	typedef struct packed {
		logic [PIX_BITS-1:0]   out_row;
		logic [PIX_BITS-1:0]   out_col;
		logic [POWER_BITS-1:0] pixel_power;
	} rsp_t;

endpackage

[src/ellipse_phantom_rasterizer_top.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ellipse phantom rasterizer
// per-pixel stopping power from a table of ellipses, nine-stage pipeline
// ---------------------------------------------------------------------------
// Load items write one ellipse table entry and give no result; query items
// give one result each, and a new query can be accepted every cycle while the
// output is not stalled. Each query builds up to four sample points (pixel
// centre or four corners) with six small multipliers, then tests every point
// against every ellipse in parallel: bound check, two 24x23 products and one
// 23x23, a split 47-bit squaring, one 96-bit add and compare, then a priority
// pick and the corner average. A load is held off until no query remains in
// flight, so after a burst of queries it waits until every stage has drained,
// which takes longer while the output is stalled. There is no clearing pass:
// an entry must be loaded before a query counts it.
module ellipse_phantom_rasterizer_top
	import epr_pkg::*;
#(
	parameter int MAX_ELLIPSES = 8,
	parameter int MAX_GRID     = 1024
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cmd_valid,
	output logic                  cmd_stall,
	input  cmd_t                  cmd,
	output logic                  rsp_valid,
	input  logic                  rsp_stall,
	output rsp_t                  rsp,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

`include "ellipse_phantom_rasterizer_top_defines.svh"

	localparam int NE = MAX_ELLIPSES;
	localparam int NS = SAMPLE_COUNT;

	// configuration registers
	logic [22:0] x_step_q, y_step_q;
	logic [10:0] x_parts_q, y_parts_q;
	logic [3:0]  ell_count_q;
	logic        corner_mode_q;

	// ellipse table, one flop row per entry
	logic signed [COORD_BITS-1:0] tbl_cx_q [NE];
	logic signed [COORD_BITS-1:0] tbl_cy_q [NE];
	logic [AXIS_BITS-1:0]         tbl_ax_q [NE];
	logic [AXIS_BITS-1:0]         tbl_ay_q [NE];
	logic [POWER_BITS-1:0]        tbl_pw_q [NE];

	// stage valids and pixel tags
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9;
	logic [19:0] pix_s1, pix_s2, pix_s3, pix_s4, pix_s5, pix_s6, pix_s7, pix_s8;

	logic adv, busy, q_acc, load_acc;
	logic [7:0] vmid;

	// stage payloads
	logic signed [13:0] xb_s1, yb_s1;
	logic signed [38:0] xl_s2, xm_s2, xr_s2, yt_s2, ym_s2, ybt_s2;
	logic [23:0] dx_s3 [NS][NE];
	logic [23:0] dy_s3 [NS][NE];
	logic        ok_s3 [NS][NE];
	logic [46:0] dxb_s4 [NS][NE];
	logic [46:0] dya_s4 [NS][NE];
	logic        ok_s4 [NS][NE];
	logic [45:0] ab_s4 [NE];
	logic [45:0] xhh_s5 [NS][NE];
	logic [46:0] xhl_s5 [NS][NE];
	logic [47:0] xll_s5 [NS][NE];
	logic [45:0] yhh_s5 [NS][NE];
	logic [46:0] yhl_s5 [NS][NE];
	logic [47:0] yll_s5 [NS][NE];
	logic        ok_s5 [NS][NE];
	logic [45:0] ahh_s5 [NE];
	logic [46:0] ahl_s5 [NE];
	logic [47:0] all_s5 [NE];
	logic [95:0] sqx_s6 [NS][NE];
	logic [95:0] sqy_s6 [NS][NE];
	logic        ok_s6 [NS][NE];
	logic [95:0] sqab_s6 [NE];
	logic        hit_s7 [NS][NE];
	logic [POWER_BITS-1:0] pw_s8 [NS];
	rsp_t        rsp_s9;

	// combinational helpers
	logic [10:0] xp_c, yp_c;
	logic signed [13:0] xb_c, yb_c;
	logic signed [14:0] xb0_c, xb1_c, xb2_c, yb0_c, yb1_c, yb2_c;
	logic signed [38:0] px_c [NS];
	logic signed [38:0] py_c [NS];
	logic [39:0] adx_c [NS][NE];
	logic [39:0] ady_c [NS][NE];
	logic [POWER_BITS-1:0] pw_c [NS];
	logic [17:0] psum_c;

	function automatic logic [95:0] sq_join(input logic [45:0] hh,
		input logic [46:0] hl, input logic [47:0] ll);
		return ({50'd0, hh} << 48) + ({49'd0, hl} << 25) + {48'd0, ll};
	endfunction

	// handshake: the whole pipe moves together, the last stage is the output
	assign adv       = !v_s9 || !rsp_stall;
	assign busy      = v_s1 | v_s2 | v_s3 | v_s4 | v_s5 | v_s6 | v_s7 | v_s8 | v_s9;
	assign vmid      = {v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8};
	// a load waits for queries in flight, so the table is steady under them
	assign cmd_stall = !adv || (cmd.mode == MODE_LOAD && busy);
	assign q_acc     = cmd_valid && !cmd_stall && cmd.mode == MODE_QUERY;
	assign load_acc  = cmd_valid && !cmd_stall && cmd.mode == MODE_LOAD;
	assign cfg_ready = 1'b1;
	assign rsp_valid = v_s9;
	assign rsp       = rsp_s9;

	// configuration writes, unknown indexes dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_step_q      <= 23'd4096;
			y_step_q      <= 23'd4096;
			x_parts_q     <= 11'd256;
			y_parts_q     <= 11'd256;
			ell_count_q   <= 4'd0;
			corner_mode_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_X_STEP:      x_step_q      <= cfg_data[22:0];
				REG_Y_STEP:      y_step_q      <= cfg_data[22:0];
				REG_X_PARTS:     x_parts_q     <= cfg_data[10:0];
				REG_Y_PARTS:     y_parts_q     <= cfg_data[10:0];
				REG_ELL_COUNT:   ell_count_q   <= cfg_data[3:0];
				REG_CORNER_MODE: corner_mode_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// table load, slots beyond the table never match
	always_ff @(posedge clk) begin
		for (int e = 0; e < NE; e++) begin
			if (load_acc && int'(cmd.entry_index) == e) begin
				tbl_cx_q[e] <= cmd.center_x;
				tbl_cy_q[e] <= cmd.center_y;
				tbl_ax_q[e] <= cmd.axis_x;
				tbl_ay_q[e] <= cmd.axis_y;
				tbl_pw_q[e] <= cmd.entry_power;
			end
		end
	end

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9} <= '0;
		end else if (adv) begin
			v_s1 <= q_acc;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
			v_s9 <= v_s8;
		end
	end

	// grid offsets in half pixels, parts clamped to the grid limit
	always_comb begin
		xp_c  = (int'(x_parts_q) > MAX_GRID) ? 11'(MAX_GRID) : x_parts_q;
		yp_c  = (int'(y_parts_q) > MAX_GRID) ? 11'(MAX_GRID) : y_parts_q;
		xb_c  = $signed({3'b000, cmd.pixel_col, 1'b0}) - $signed({3'b000, xp_c});
		yb_c  = $signed({3'b000, yp_c}) - $signed({3'b000, cmd.pixel_row, 1'b0});
		xb0_c = {xb_s1[13], xb_s1};
		xb1_c = xb0_c + 15'sd1;
		xb2_c = xb0_c + 15'sd2;
		yb0_c = {yb_s1[13], yb_s1};
		yb1_c = yb0_c - 15'sd1;
		yb2_c = yb0_c - 15'sd2;
	end

	// sample points: centre in lane 0, or the four corners
	always_comb begin
		px_c[0] = corner_mode_q ? xl_s2 : xm_s2;
		py_c[0] = corner_mode_q ? yt_s2 : ym_s2;
		px_c[1] = xr_s2;
		py_c[1] = yt_s2;
		px_c[2] = xr_s2;
		py_c[2] = ybt_s2;
		px_c[3] = xl_s2;
		py_c[3] = ybt_s2;
	end

	// distances from each doubled centre
	always_comb begin
		for (int s = 0; s < NS; s++) begin
			for (int e = 0; e < NE; e++) begin
				logic signed [39:0] ddx, ddy;
				ddx = $signed({px_c[s][38], px_c[s]}) -
					$signed({{15{tbl_cx_q[e][COORD_BITS-1]}}, tbl_cx_q[e], 1'b0});
				ddy = $signed({py_c[s][38], py_c[s]}) -
					$signed({{15{tbl_cy_q[e][COORD_BITS-1]}}, tbl_cy_q[e], 1'b0});
				adx_c[s][e] = ddx[39] ? 40'(-ddx) : 40'(ddx);
				ady_c[s][e] = ddy[39] ? 40'(-ddy) : 40'(ddy);
			end
		end
	end

	// first containing entry wins, entries past the count are off
	always_comb begin
		for (int s = 0; s < NS; s++) begin
			pw_c[s] = '0;
			for (int e = NE - 1; e >= 0; e--) begin
				if (hit_s7[s][e] && e < int'(ell_count_q))
					pw_c[s] = tbl_pw_q[e];
			end
		end
		psum_c = 18'(pw_s8[0]) + 18'(pw_s8[1]) + 18'(pw_s8[2]) + 18'(pw_s8[3]);
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (adv) begin
			// s1: half-pixel offsets
			pix_s1 <= {cmd.pixel_row, cmd.pixel_col};
			xb_s1  <= xb_c;
			yb_s1  <= yb_c;
			// s2: edge and centre coordinates, doubled units
			pix_s2 <= pix_s1;
			xl_s2  <= xb0_c * $signed({1'b0, x_step_q});
			xm_s2  <= xb1_c * $signed({1'b0, x_step_q});
			xr_s2  <= xb2_c * $signed({1'b0, x_step_q});
			yt_s2  <= yb0_c * $signed({1'b0, y_step_q});
			ym_s2  <= yb1_c * $signed({1'b0, y_step_q});
			ybt_s2 <= yb2_c * $signed({1'b0, y_step_q});
			pix_s3 <= pix_s2;
			pix_s4 <= pix_s3;
			pix_s5 <= pix_s4;
			pix_s6 <= pix_s5;
			pix_s7 <= pix_s6;
			pix_s8 <= pix_s7;
			for (int e = 0; e < NE; e++) begin
				// s4 to s6: a*b and its square
				ab_s4[e]   <= tbl_ax_q[e] * tbl_ay_q[e];
				ahh_s5[e]  <= {1'b0, ab_s4[e][45:24]} * {1'b0, ab_s4[e][45:24]};
				ahl_s5[e]  <= {1'b0, ab_s4[e][45:24]} * ab_s4[e][23:0];
				all_s5[e]  <= ab_s4[e][23:0] * ab_s4[e][23:0];
				sqab_s6[e] <= sq_join(ahh_s5[e], ahl_s5[e], all_s5[e]);
				for (int s = 0; s < NS; s++) begin
					// s3: bound check, survivors fit 24 bits
					ok_s3[s][e] <= (tbl_ax_q[e] != '0) &&
						(adx_c[s][e] <= {16'd0, tbl_ax_q[e], 1'b0}) &&
						(ady_c[s][e] <= {16'd0, tbl_ay_q[e], 1'b0});
					dx_s3[s][e] <= adx_c[s][e][23:0];
					dy_s3[s][e] <= ady_c[s][e][23:0];
					// s4: dx*b and dy*a
					dxb_s4[s][e] <= dx_s3[s][e] * tbl_ay_q[e];
					dya_s4[s][e] <= dy_s3[s][e] * tbl_ax_q[e];
					ok_s4[s][e]  <= ok_s3[s][e];
					// s5: squares as partial products
					xhh_s5[s][e] <= dxb_s4[s][e][46:24] * dxb_s4[s][e][46:24];
					xhl_s5[s][e] <= dxb_s4[s][e][46:24] * dxb_s4[s][e][23:0];
					xll_s5[s][e] <= dxb_s4[s][e][23:0] * dxb_s4[s][e][23:0];
					yhh_s5[s][e] <= dya_s4[s][e][46:24] * dya_s4[s][e][46:24];
					yhl_s5[s][e] <= dya_s4[s][e][46:24] * dya_s4[s][e][23:0];
					yll_s5[s][e] <= dya_s4[s][e][23:0] * dya_s4[s][e][23:0];
					ok_s5[s][e]  <= ok_s4[s][e];
					// s6: assembled squares
					sqx_s6[s][e] <= sq_join(xhh_s5[s][e], xhl_s5[s][e], xll_s5[s][e]);
					sqy_s6[s][e] <= sq_join(yhh_s5[s][e], yhl_s5[s][e], yll_s5[s][e]);
					ok_s6[s][e]  <= ok_s5[s][e];
					// s7: ellipse inequality
					hit_s7[s][e] <= ok_s6[s][e] &&
						((sqx_s6[s][e] + sqy_s6[s][e]) <= (sqab_s6[e] << 2));
				end
			end
			// s8: sample powers
			for (int s = 0; s < NS; s++)
				pw_s8[s] <= pw_c[s];
			// s9: output item, corner mode averages with truncation
			rsp_s9.out_row     <= pix_s8[19:10];
			rsp_s9.out_col     <= pix_s8[9:0];
			rsp_s9.pixel_power <= corner_mode_q ? psum_c[17:2] : pw_s8[0];
		end
	end

	`EPR_ASSERT_IMP(a_load_when_drained, load_acc, !busy)
	`EPR_ASSERT_NXT(a_pipe_holds, !adv, $stable(vmid))
	`EPR_ASSERT_NXT(a_s8_reaches_out, v_s8 && adv, rsp_valid)

endmodule
